FILE: hw/rtl/ufc_pkg.sv
// ----------------------------------------------------------------------------
// ufc_pkg: shared types, constants and glyph lookup
// Command and status structs, controller state codes, register indexes and
// the reverse font tables used by the UTF-8 to font code converter.
// ----------------------------------------------------------------------------
package ufc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CP_W    = 21;
	localparam int unsigned CFG_W   = 9;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned BUF_DEPTH = 4;
	localparam int unsigned FILL_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_FONT_KIND   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT = 2'd2;

	localparam logic FONT_LEGEND = 1'b0;
	localparam logic FONT_GUI    = 1'b1;

	localparam logic [7:0] RST_FIRST_CODE  = 8'd32;
	localparam logic [8:0] RST_GLYPH_COUNT = 9'd96;

	localparam logic [7:0]      QMARK     = 8'h3F;
	localparam logic [CP_W-1:0] CHAR_ZERO = 21'h30;
	localparam logic [CP_W-1:0] CHAR_NINE = 21'h39;

	localparam logic [7:0] LEAD3_MIN = 8'hF0;
	localparam logic [7:0] LEAD2_MIN = 8'hE0;
	localparam logic [7:0] LEAD1_MIN = 8'hC0;
	localparam logic [1:0] FOLLOW_TAG = 2'b10;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WORK = 2'b10
	} state_t;

	typedef struct packed {
		logic append;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic drained;
	} stat_t;

	typedef struct packed {
		logic [7:0] code;
		logic       rejected;
	} map_t;

	function automatic map_t map_glyph(logic kind, logic [CP_W-1:0] cp,
			logic [7:0] first, logic [8:0] count);
		map_t       r;
		logic       hit;
		logic [7:0] code;
		logic [9:0] upper;
		logic       in_range;
		logic       digit;
		hit  = 1'b0;
		code = QMARK;
		if (cp[CP_W-1:8] == '0) begin
			if (kind == FONT_LEGEND) begin
				hit = 1'b1;
				case (cp[7:0])
					8'hE4: code = 8'h30;
					8'hE0: code = 8'h31;
					8'hE8: code = 8'h32;
					8'hE9: code = 8'h33;
					8'hEA: code = 8'h34;
					8'hF6: code = 8'h35;
					8'hFC: code = 8'h36;
					8'hE1: code = 8'h37;
					8'hED: code = 8'h38;
					8'hDF: code = 8'h39;
					8'h31: code = 8'h5B;
					8'h30: code = 8'h5C;
					8'hA9: code = 8'h5D;
					8'hAE: code = 8'h5E;
					default: hit = 1'b0;
				endcase
			end else begin
				hit = 1'b1;
				case (cp[7:0])
					8'hDC: code = 8'h5B;
					8'hD6: code = 8'h5C;
					8'hC4: code = 8'h5D;
					default: hit = 1'b0;
				endcase
			end
		end
		upper    = {2'b00, first} + {1'b0, count};
		in_range = (cp >= {13'd0, first}) && (cp < {11'd0, upper});
		digit    = (kind == FONT_LEGEND) && (cp >= CHAR_ZERO) && (cp <= CHAR_NINE);
		if (!hit && in_range && !digit) begin
			code = cp[7:0];
			hit  = 1'b1;
		end
		if (!hit) begin
			code = QMARK;
		end
		r.code     = code;
		r.rejected = !hit;
		return r;
	endfunction

endpackage

FILE: hw/rtl/ufc_if.sv
// ----------------------------------------------------------------------------
// ufc_if: stream channels of the converter
// Byte channel into the block and glyph channel out of it.
// ----------------------------------------------------------------------------
interface ufc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface ufc_glyph_if;
	logic        valid;
	logic        ready;
	logic [7:0]  font_code;
	logic [20:0] code_point;
	logic        rejected;
	logic        last_of_text;

	modport source (output valid, output font_code, output code_point,
		output rejected, output last_of_text, input ready);
	modport sink   (input valid, input font_code, input code_point,
		input rejected, input last_of_text, output ready);
endinterface

FILE: hw/rtl/utf8_to_font_code_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_font_code_unit: UTF-8 byte stream to font code converter
// Decodes UTF-8 text and gives one font code word per decoded code point.
// ----------------------------------------------------------------------------
// Usage:
//   text  : one byte word per handshake, end_of_text on the final byte.
//   glyph : one word per code point: font code, code point, rejected flag and
//           last_of_text on the final word of a string.
//   cfg_* : write font kind, first code and glyph count while the block idles.
// Timing: a byte is taken into the byte buffer, then each code point that it
//   completes takes one decode step that writes the result word, at most four
//   words per byte; a byte that releases no word, or leaves an unfinished
//   sequence behind, takes one more pass through ST_WORK before text.ready
//   returns. The next byte is taken only after the last one is done. The first
//   word is valid once the byte buffer and then the result word are written.
//   The byte buffer head decoder, shared across steps, sets this pace.
// Reset: font kind GUI text, first code 32, glyph count 96, buffer empty.
// Stall: the result word holds while glyph.ready is low; the decode step
//   waits for the output register, and text.ready stays low meanwhile.
// ----------------------------------------------------------------------------
module utf8_to_font_code_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	ufc_byte_if.sink                      text,
	ufc_glyph_if.source                   glyph,
	input  logic                          cfg_we,
	input  logic [ufc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ufc_pkg::CFG_W-1:0]     cfg_data
);

	ufc_pkg::cmd_t  cmd;
	ufc_pkg::stat_t stat;

	ufc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text.valid),
		.in_ready  (text.ready),
		.out_valid (glyph.valid),
		.out_ready (glyph.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ufc_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_byte      (text.in_byte),
		.end_of_text  (text.end_of_text),
		.cmd          (cmd),
		.stat         (stat),
		.font_code    (glyph.font_code),
		.code_point   (glyph.code_point),
		.rejected     (glyph.rejected),
		.last_of_text (glyph.last_of_text)
	);

endmodule

FILE: hw/rtl/ufc_ctrl.sv
// ----------------------------------------------------------------------------
// ufc_ctrl: sequencing controller
// Takes a byte word, then steps the decoder once per code point until the
// buffer is empty or holds an unfinished sequence. Owns the output valid.
// ----------------------------------------------------------------------------
module ufc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ufc_pkg::stat_t stat,
	output ufc_pkg::cmd_t  cmd
);

	ufc_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd.append = 1'b0;
		cmd.step   = 1'b0;
		in_ready   = 1'b0;
		unique case (state_q)
			ufc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.append = 1'b1;
					state_d    = ufc_pkg::ST_WORK;
				end
			end
			ufc_pkg::ST_WORK: begin
				if (!stat.emit) begin
					state_d = ufc_pkg::ST_IDLE;
				end else if (slot_free) begin
					cmd.step = 1'b1;
					if (stat.drained) begin
						state_d = ufc_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = ufc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ufc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/ufc_dpath.sv
// ----------------------------------------------------------------------------
// ufc_dpath: byte buffer, sequence decoder and glyph lookup
// Holds the unfinished sequence, decodes one code point from its head per
// step, maps it onto the font and holds the result word.
// ----------------------------------------------------------------------------
module ufc_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ufc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ufc_pkg::CFG_W-1:0]   cfg_data,
	input  logic [7:0]                  in_byte,
	input  logic                        end_of_text,
	input  ufc_pkg::cmd_t               cmd,
	output ufc_pkg::stat_t              stat,
	output logic [7:0]                  font_code,
	output logic [ufc_pkg::CP_W-1:0]    code_point,
	output logic                        rejected,
	output logic                        last_of_text
);

	logic [7:0]                 buf_q [ufc_pkg::BUF_DEPTH];
	logic [ufc_pkg::FILL_W-1:0] fill_q;
	logic                       eot_q;
	logic                       font_kind_q;
	logic [7:0]                 first_code_q;
	logic [8:0]                 glyph_count_q;

	logic [7:0]                 font_code_q;
	logic [ufc_pkg::CP_W-1:0]   code_point_q;
	logic                       rejected_q;
	logic                       last_q;

	logic [7:0]                 lead;
	logic [2:0]                 extra;
	logic [2:0]                 avail;
	logic [3:1]                 fol_ok;
	logic                       bad;
	logic                       complete;
	logic [ufc_pkg::CP_W-1:0]   full_cp;
	logic [ufc_pkg::CP_W-1:0]   value;
	logic [2:0]                 consume;
	logic [ufc_pkg::FILL_W-1:0] remain;
	ufc_pkg::map_t              mapped;

	always_comb begin
		lead   = buf_q[0];
		avail  = fill_q - 3'd1;
		fol_ok = {buf_q[3][7:6] == ufc_pkg::FOLLOW_TAG,
			buf_q[2][7:6] == ufc_pkg::FOLLOW_TAG,
			buf_q[1][7:6] == ufc_pkg::FOLLOW_TAG};
		if (lead >= ufc_pkg::LEAD3_MIN) begin
			extra   = 3'd3;
			full_cp = {lead[2:0], buf_q[1][5:0], buf_q[2][5:0], buf_q[3][5:0]};
		end else if (lead >= ufc_pkg::LEAD2_MIN) begin
			extra   = 3'd2;
			full_cp = {5'd0, lead[3:0], buf_q[1][5:0], buf_q[2][5:0]};
		end else if (lead >= ufc_pkg::LEAD1_MIN) begin
			extra   = 3'd1;
			full_cp = {10'd0, lead[4:0], buf_q[1][5:0]};
		end else begin
			extra   = 3'd0;
			full_cp = {13'd0, lead};
		end
		bad = (extra >= 3'd1 && avail >= 3'd1 && !fol_ok[1])
			|| (extra >= 3'd2 && avail >= 3'd2 && !fol_ok[2])
			|| (extra >= 3'd3 && avail >= 3'd3 && !fol_ok[3]);
		complete = avail >= extra;
		if (!bad && complete) begin
			value   = full_cp;
			consume = extra + 3'd1;
		end else begin
			value   = {13'd0, lead};
			consume = 3'd1;
		end
		remain       = fill_q - consume;
		stat.emit    = bad || complete || eot_q;
		stat.drained = remain == '0;
		mapped       = ufc_pkg::map_glyph(font_kind_q, value, first_code_q, glyph_count_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_kind_q   <= ufc_pkg::FONT_GUI;
			first_code_q  <= ufc_pkg::RST_FIRST_CODE;
			glyph_count_q <= ufc_pkg::RST_GLYPH_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ufc_pkg::CFG_FONT_KIND:   font_kind_q   <= cfg_data[0];
				ufc_pkg::CFG_FIRST_CODE:  first_code_q  <= cfg_data[7:0];
				ufc_pkg::CFG_GLYPH_COUNT: glyph_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// buffer fill and end mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			eot_q  <= 1'b0;
		end else if (cmd.append) begin
			fill_q <= fill_q + 3'd1;
			eot_q  <= end_of_text;
		end else if (cmd.step) begin
			fill_q <= remain;
		end
	end

	// byte buffer: append at the fill point, drop consumed bytes from the head
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			buf_q[fill_q[1:0]] <= in_byte;
		end else if (cmd.step) begin
			case (consume)
				3'd1: begin
					buf_q[0] <= buf_q[1];
					buf_q[1] <= buf_q[2];
					buf_q[2] <= buf_q[3];
				end
				3'd2: begin
					buf_q[0] <= buf_q[2];
					buf_q[1] <= buf_q[3];
				end
				3'd3: begin
					buf_q[0] <= buf_q[3];
				end
				default: ;
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			font_code_q  <= mapped.code;
			code_point_q <= value;
			rejected_q   <= mapped.rejected;
			last_q       <= eot_q && (remain == '0);
		end
	end

	assign font_code    = font_code_q;
	assign code_point   = code_point_q;
	assign rejected     = rejected_q;
	assign last_of_text = last_q;

endmodule

FILE: sim/utf8_to_font_code_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_font_code_unit_tb: self-checking bench for the UTF-8 font converter
// Streams directed and random UTF-8 text through the block and predicts every
// glyph word: well-formed sequences, stray and broken bytes, strings cut off
// mid-sequence, under several font setups and with random stalls on both ends.
// ----------------------------------------------------------------------------
module utf8_to_font_code_unit_tb;

	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned SETTLE      = 10;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned SEG_BYTES   = 56;

	localparam logic [7:0] LEG_FROM [14] = '{8'hE4, 8'hE0, 8'hE8, 8'hE9, 8'hEA, 8'hF6,
		8'hFC, 8'hE1, 8'hED, 8'hDF, 8'h31, 8'h30, 8'hA9, 8'hAE};
	localparam logic [7:0] LEG_TO   [14] = '{8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
		8'h36, 8'h37, 8'h38, 8'h39, 8'h5B, 8'h5C, 8'h5D, 8'h5E};
	localparam logic [7:0] GUI_FROM [3]  = '{8'hDC, 8'hD6, 8'hC4};
	localparam logic [7:0] GUI_TO   [3]  = '{8'h5B, 8'h5C, 8'h5D};

	// bit 8 marks the end of the string
	localparam logic [8:0] OPENING [28] = '{
		9'h041, 9'h000, 9'h07F, 9'h030,
		9'h0C3, 9'h09C, 9'h0C3, 9'h096,
		9'h0E2, 9'h082, 9'h0AC,
		9'h0F0, 9'h09F, 9'h098, 9'h080,
		9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
		9'h080, 9'h0C3, 9'h041,
		9'h0E2, 9'h182, 9'h1FF,
		9'h0F0, 9'h09F, 9'h041
	};

	typedef struct packed {
		logic [7:0]  font_code;
		logic [20:0] code_point;
		logic        rejected;
		logic        last_of_text;
	} glyph_word_t;

	class glyph_predictor;
		logic                font_kind;
		logic [7:0]          first_code;
		logic [8:0]          glyph_count;
		logic [7:0]          held [3];
		int                  held_n;
		glyph_word_t         expected_glyphs [$];
		int unsigned         errors;
		int unsigned         words_checked;
		int unsigned         bytes_taken;

		function new();
			font_kind     = ufc_pkg::FONT_GUI;
			first_code    = ufc_pkg::RST_FIRST_CODE;
			glyph_count   = ufc_pkg::RST_GLYPH_COUNT;
			held_n        = 0;
			errors        = 0;
			words_checked = 0;
			bytes_taken   = 0;
		endfunction

		function void write_reg(logic [ufc_pkg::CFG_IDX_W-1:0] idx,
				logic [ufc_pkg::CFG_W-1:0] data);
			case (idx)
				ufc_pkg::CFG_FONT_KIND:   font_kind   = data[0];
				ufc_pkg::CFG_FIRST_CODE:  first_code  = data[7:0];
				ufc_pkg::CFG_GLYPH_COUNT: glyph_count = data;
				default: ;
			endcase
		endfunction

		function void queue_glyph(glyph_word_t g);
			expected_glyphs.insert(expected_glyphs.size(), g);
		endfunction

		function glyph_word_t lookup(logic [20:0] cp);
			glyph_word_t g;
			logic        found;
			logic        digit;
			g.code_point   = cp;
			g.font_code    = ufc_pkg::QMARK;
			g.last_of_text = 1'b0;
			found          = 1'b0;
			if (font_kind == ufc_pkg::FONT_LEGEND) begin
				for (int k = 0; k < 14; k++)
					if (cp == 21'(LEG_FROM[k])) begin
						g.font_code = LEG_TO[k];
						found       = 1'b1;
					end
			end else begin
				for (int k = 0; k < 3; k++)
					if (cp == 21'(GUI_FROM[k])) begin
						g.font_code = GUI_TO[k];
						found       = 1'b1;
					end
			end
			digit = (font_kind == ufc_pkg::FONT_LEGEND) && cp >= 21'h30 && cp <= 21'h39;
			if (!found && !digit && int'(cp) >= int'(first_code)
					&& int'(cp) < int'(first_code) + int'(glyph_count)) begin
				g.font_code = cp[7:0];
				found       = 1'b1;
			end
			g.rejected = !found;
			return g;
		endfunction

		function void take_byte(logic [7:0] b, logic eot);
			logic [7:0]  pool [4];
			logic [7:0]  lead;
			logic [20:0] v;
			logic        bad;
			int          n;
			int          pos;
			int          extra;
			int          avail;
			int          base;
			base = expected_glyphs.size();
			bytes_taken++;
			for (int i = 0; i < held_n; i++)
				pool[i] = held[i];
			pool[held_n] = b;
			n   = held_n + 1;
			pos = 0;
			while (pos < n) begin
				lead  = pool[pos];
				v     = 21'(lead);
				extra = 0;
				avail = n - pos - 1;
				bad   = 1'b0;
				if (lead >= ufc_pkg::LEAD3_MIN) begin
					extra = 3;
					v     = 21'(lead[2:0]);
				end else if (lead >= ufc_pkg::LEAD2_MIN) begin
					extra = 2;
					v     = 21'(lead[3:0]);
				end else if (lead >= ufc_pkg::LEAD1_MIN) begin
					extra = 1;
					v     = 21'(lead[4:0]);
				end
				for (int k = 1; k <= extra && k <= avail; k++) begin
					if (pool[pos+k][7:6] != ufc_pkg::FOLLOW_TAG) begin
						bad = 1'b1;
						break;
					end
					v = {v[14:0], pool[pos+k][5:0]};
				end
				if (bad) begin
					queue_glyph(lookup(21'(lead)));
					pos++;
				end else if (avail >= extra) begin
					queue_glyph(lookup(v));
					pos += extra + 1;
				end else if (eot) begin
					queue_glyph(lookup(21'(lead)));
					pos++;
				end else begin
					break;
				end
			end
			held_n = n - pos;
			for (int i = 0; i < held_n; i++)
				held[i] = pool[pos+i];
			if (eot && expected_glyphs.size() > base)
				expected_glyphs[expected_glyphs.size()-1].last_of_text = 1'b1;
		endfunction

		function void check_glyph(glyph_word_t got);
			glyph_word_t want;
			words_checked++;
			if (expected_glyphs.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("glyph word with nothing expected: ",
						"code %02h cp %06h rej %0d last %0d",
						got.font_code, got.code_point, got.rejected, got.last_of_text);
				return;
			end
			want = expected_glyphs.pop_front();
			if (got.font_code !== want.font_code || got.code_point !== want.code_point
					|| got.rejected !== want.rejected
					|| got.last_of_text !== want.last_of_text) begin
				errors++;
				if (errors <= 10)
					$display("glyph mismatch: code %02h/%02h cp %06h/%06h ",
						want.font_code, got.font_code, want.code_point, got.code_point,
						"rej %0d/%0d last %0d/%0d (exp/act)",
						want.rejected, got.rejected, want.last_of_text, got.last_of_text);
			end
		endfunction

		function void close_out();
			if (expected_glyphs.size() != 0) begin
				errors += expected_glyphs.size();
				$display("%0d glyph words never arrived", expected_glyphs.size());
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [ufc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ufc_pkg::CFG_W-1:0]     cfg_data;
	logic                          text_took;
	int unsigned                   send_idle;
	int unsigned                   recv_idle;
	int unsigned                   hold_req_cnt;
	int unsigned                   hold_seen;
	int unsigned                   hold_left;
	int unsigned                   quiet;
	int unsigned                   setups;
	glyph_predictor                sb = new();

	ufc_byte_if  text_if ();
	ufc_glyph_if glyph_if ();

	utf8_to_font_code_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text_if),
		.glyph     (glyph_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		text_took <= text_if.valid && text_if.ready;
		if (arst_n) begin
			if (text_if.valid && text_if.ready)
				sb.take_byte(text_if.in_byte, text_if.end_of_text);
			if (glyph_if.valid && glyph_if.ready)
				sb.check_glyph('{glyph_if.font_code, glyph_if.code_point,
					glyph_if.rejected, glyph_if.last_of_text});
			if ((text_if.valid && text_if.ready) || (glyph_if.valid && glyph_if.ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// hold off for a long stretch on request, else stall at random
	always @(negedge clk) begin
		if (hold_req_cnt != hold_seen) begin
			hold_seen = hold_req_cnt;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			glyph_if.ready <= 1'b0;
		end else begin
			glyph_if.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eot);
		while ($urandom_range(99) < send_idle) begin
			text_if.valid <= 1'b0;
			@(negedge clk);
		end
		text_if.valid       <= 1'b1;
		text_if.in_byte     <= b;
		text_if.end_of_text <= eot;
		@(negedge clk);
		while (!text_took)
			@(negedge clk);
	endtask

	task automatic drain(input int unsigned extra);
		text_if.valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.expected_glyphs.size() != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic load_font_setup(input logic [ufc_pkg::CFG_W-1:0] kind_word,
			input logic [ufc_pkg::CFG_W-1:0] first_word,
			input logic [ufc_pkg::CFG_W-1:0] count_word);
		cfg_we    <= 1'b1;
		cfg_index <= ufc_pkg::CFG_FONT_KIND;
		cfg_data  <= kind_word;
		@(negedge clk);
		cfg_index <= ufc_pkg::CFG_FIRST_CODE;
		cfg_data  <= first_word;
		@(negedge clk);
		cfg_index <= ufc_pkg::CFG_GLYPH_COUNT;
		cfg_data  <= count_word;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(ufc_pkg::CFG_FONT_KIND, kind_word);
		sb.write_reg(ufc_pkg::CFG_FIRST_CODE, first_word);
		sb.write_reg(ufc_pkg::CFG_GLYPH_COUNT, count_word);
		setups++;
	endtask

	task automatic send_random_run(inout int left);
		logic [7:0]  seq [4];
		logic [20:0] v;
		logic [7:0]  b;
		int          len;
		int          r;
		int          cut;
		int          need;
		int          good;
		r   = $urandom_range(99);
		len = 1;
		if (r < 28) begin
			seq[0] = ($urandom_range(3) == 0) ? 8'($urandom_range(127))
				: 8'($urandom_range(127, 32));
		end else if (r < 48) begin
			case ($urandom_range(2))
				0:       v = 21'(LEG_FROM[$urandom_range(13)]);
				1:       v = 21'(GUI_FROM[$urandom_range(2)]);
				default: v = 21'($urandom_range(2047));
			endcase
			seq[0] = {3'b110, v[10:6]};
			seq[1] = {2'b10, v[5:0]};
			len    = 2;
		end else if (r < 63) begin
			v      = 21'($urandom_range(65535));
			seq[0] = {4'hE, v[15:12]};
			seq[1] = {2'b10, v[11:6]};
			seq[2] = {2'b10, v[5:0]};
			len    = 3;
		end else if (r < 73) begin
			seq[0] = 8'hF0 | 8'($urandom_range(15));
			for (int k = 1; k < 4; k++)
				seq[k] = {2'b10, 6'($urandom_range(63))};
			len = 4;
		end else if (r < 87) begin
			seq[0] = 8'($urandom_range(255));
		end else begin
			seq[0] = 8'($urandom_range(255, 192));
			need   = (seq[0] >= ufc_pkg::LEAD3_MIN) ? 3
				: (seq[0] >= ufc_pkg::LEAD2_MIN) ? 2 : 1;
			good   = $urandom_range(need - 1);
			for (int k = 1; k <= good; k++)
				seq[k] = {2'b10, 6'($urandom_range(63))};
			b = 8'($urandom_range(255));
			while (b[7:6] == ufc_pkg::FOLLOW_TAG)
				b = 8'($urandom_range(255));
			seq[good+1] = b;
			len = good + 2;
		end
		cut = -1;
		if ($urandom_range(7) == 0)
			cut = len - 1;
		else if (len > 1 && $urandom_range(19) == 0)
			cut = $urandom_range(len - 2);
		for (int k = 0; k < len; k++)
			send_byte(seq[k], k == cut);
		left -= len;
	endtask

	initial begin
		int   left;
		logic paused;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = ufc_pkg::CFG_FONT_KIND;
		cfg_data            = '0;
		text_if.valid       = 1'b0;
		text_if.in_byte     = 8'h00;
		text_if.end_of_text = 1'b0;
		glyph_if.ready      = 1'b0;
		text_took           = 1'b0;
		send_idle           = 22;
		recv_idle           = 55;
		hold_req_cnt        = 0;
		hold_seen           = 0;
		hold_left           = 0;
		quiet               = 0;
		setups              = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (OPENING[i])
			send_byte(OPENING[i][7:0], OPENING[i][8]);
		drain(SETTLE);

		for (int seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin
					send_idle = 22;
					recv_idle <= 55;
				end
				1: begin
					send_idle = 55;
					recv_idle <= 22;
				end
				default: begin
					send_idle = 0;
					recv_idle <= 0;
				end
			endcase
			case (seg)
				0: load_font_setup({8'($urandom), ufc_pkg::FONT_LEGEND}, 9'd32, 9'd96);
				1: load_font_setup({8'($urandom), ufc_pkg::FONT_GUI}, 9'd0, 9'd256);
				2: load_font_setup({8'($urandom), ufc_pkg::FONT_LEGEND}, 9'h1FF, 9'd256);
				3: load_font_setup({8'($urandom), ufc_pkg::FONT_GUI}, 9'h100, 9'd0);
				4: load_font_setup({8'($urandom), ufc_pkg::FONT_LEGEND}, 9'h030, 9'd10);
				default: load_font_setup(9'($urandom), 9'($urandom), 9'($urandom_range(256)));
			endcase
			if (seg == 1)
				hold_req_cnt <= hold_req_cnt + 1;
			left   = SEG_BYTES;
			paused = 1'b0;
			while (left > 0) begin
				if (seg == 3 && !paused && left < SEG_BYTES / 2) begin
					drain(0);
					paused = 1'b1;
				end
				send_random_run(left);
			end
			drain(SETTLE);
		end

		sb.close_out();
		$display("summary: %0d text bytes in, %0d glyph words checked, ",
			sb.bytes_taken, sb.words_checked,
			"%0d font setups, %0d errors", setups, sb.errors);
		$display("summary: edge-case strings, broken and cut-off sequences, ",
			"three stall mixes, long output hold-off");
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
